@@ hdl/tvbf_pkg.sv @@
// tvbf_pkg: shared constants and types for the visible text byte filter
// no dependencies; used by the config interface and every module of the block

package tvbf_pkg;

	// default width of the line number in decimal digits
	localparam int NUMBER_DIGITS_DEF = 6;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_LINES     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_NONBLANK  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINTING = 3'd5;

	// character codes
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [6:0] CH_DEL7   = 7'h7F;
	localparam logic [6:0] CTRL_LIMIT = 7'h20;
	localparam logic [6:0] CTRL_FLIP  = 7'h40;
	localparam logic [3:0] BCD_NINE   = 4'd9;

	// bytes the body of one item can expand to (M - ^ x)
	localparam int BODY_MAX = 4;

	typedef struct packed {
		logic squeeze_blank;
		logic number_lines;
		logic number_nonblank_only;
		logic show_ends;
		logic show_tabs;
		logic show_nonprinting;
	} cfg_t;

endpackage

@@ hdl/tvbf_ifs.sv @@
// tvbf_ifs: valid/ready channel interfaces for input items, result items and config writes
// depends on tvbf_pkg for the register index width

interface tvbf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       file_start;

	modport source (output valid, data_byte, file_start, input ready);
	modport sink (input valid, data_byte, file_start, output ready);
endinterface

interface tvbf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, out_byte, last, input ready);
	modport sink (input valid, out_byte, last, output ready);
endinterface

interface tvbf_cfg_if import tvbf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic                 data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/tvbf_format.sv @@
// tvbf_format: combinational expansion of one input byte into its output byte run
// and the next line state; depends on tvbf_pkg

module tvbf_format import tvbf_pkg::*; #(
	parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF,
	parameter int MAX_RES = NUMBER_DIGITS + 5,
	parameter int CNT_W = $clog2(MAX_RES + 1)
) (
	input  cfg_t                            cfg,
	input  logic [7:0]                      data_byte,
	input  logic                            file_start,
	input  logic                            after_nl,
	input  logic                            blank_seen,
	input  logic [4*NUMBER_DIGITS-1:0]      line_cnt,
	output logic [MAX_RES-1:0][7:0]         res_bytes,
	output logic [CNT_W-1:0]                res_cnt,
	output logic                            after_nl_nxt,
	output logic                            blank_seen_nxt,
	output logic [4*NUMBER_DIGITS-1:0]      line_cnt_nxt
);

	localparam int ND = NUMBER_DIGITS;

	logic                       an_e;
	logic                       bs_e;
	logic [4*ND-1:0]            cnt_e;
	logic [4*ND-1:0]            cnt_inc;
	logic                       is_nl;
	logic                       is_tab;
	logic                       squeezed;
	logic                       do_num;
	logic [ND:0][7:0]           pre;
	logic [BODY_MAX-1:0][7:0]   body;
	logic [2:0]                 blen;
	logic [6:0]                 c7;
	logic                       ctrl;
	logic [7:0]                 p0;
	logic [7:0]                 p1;
	logic [1:0]                 plen;

	// file start acts before this byte
	assign an_e  = file_start | after_nl;
	assign bs_e  = ~file_start & blank_seen;
	assign cnt_e = file_start ? '0 : line_cnt;

	assign is_nl  = (data_byte == CH_NL);
	assign is_tab = (data_byte == CH_TAB);

	assign squeezed = an_e & cfg.squeeze_blank & is_nl & bs_e;
	assign do_num   = an_e & cfg.number_lines & (~cfg.number_nonblank_only | ~is_nl)
		& ~squeezed;

	assign after_nl_nxt   = is_nl;
	assign blank_seen_nxt = (an_e & cfg.squeeze_blank) ? is_nl : bs_e;
	assign line_cnt_nxt   = do_num ? cnt_inc : cnt_e;

	// bcd increment, saturating at all nines
	always_comb begin
		logic       all9;
		logic       low9;
		logic [3:0] d;
		all9 = 1'b1;
		low9 = 1'b1;
		for (int i = 0; i < ND; i++) begin
			all9 = all9 & (cnt_e[4*i +: 4] == BCD_NINE);
		end
		for (int i = 0; i < ND; i++) begin
			d = cnt_e[4*i +: 4];
			if (!all9 && low9) begin
				cnt_inc[4*i +: 4] = (d == BCD_NINE) ? 4'd0 : d + 4'd1;
			end else begin
				cnt_inc[4*i +: 4] = d;
			end
			low9 = low9 & (d == BCD_NINE);
		end
	end

	// number prefix, leading zeros as spaces, lowest digit always shown
	always_comb begin
		logic       nz;
		logic [3:0] d;
		nz = 1'b0;
		for (int i = ND - 1; i >= 0; i--) begin
			d = cnt_inc[4*i +: 4];
			if (d == 4'd0 && !nz && i > 0) begin
				pre[ND-1-i] = CH_SPACE;
			end else begin
				nz = 1'b1;
				pre[ND-1-i] = CH_ZERO + {4'h0, d};
			end
		end
		pre[ND] = CH_TAB;
	end

	assign c7   = data_byte[6:0];
	assign ctrl = (c7 < CTRL_LIMIT) || (c7 == CH_DEL7);

	always_comb begin
		if (ctrl) begin
			p0   = CH_CARET;
			p1   = (c7 == CH_DEL7) ? CH_QMARK : {1'b0, c7 | CTRL_FLIP};
			plen = 2'd2;
		end else begin
			p0   = {1'b0, c7};
			p1   = 8'h00;
			plen = 2'd1;
		end
	end

	always_comb begin
		body = '0;
		blen = 3'd1;
		if (is_nl) begin
			if (cfg.show_ends) begin
				body[0] = CH_DOLLAR;
				body[1] = CH_NL;
				blen    = 3'd2;
			end else begin
				body[0] = CH_NL;
			end
		end else if (is_tab) begin
			if (cfg.show_tabs) begin
				body[0] = CH_CARET;
				body[1] = CH_I;
				blen    = 3'd2;
			end else begin
				body[0] = CH_TAB;
			end
		end else if (cfg.show_nonprinting) begin
			if (data_byte[7]) begin
				body[0] = CH_M;
				body[1] = CH_DASH;
				body[2] = p0;
				body[3] = p1;
				blen    = 3'd2 + {1'b0, plen};
			end else begin
				body[0] = p0;
				body[1] = p1;
				blen    = {1'b0, plen};
			end
		end else begin
			body[0] = data_byte;
		end
	end

	// the body follows the prefix when numbering, else starts at slot zero
	always_comb begin
		logic [1:0] bi;
		for (int k = 0; k < MAX_RES; k++) begin
			if (do_num) begin
				bi = 2'(k - ND - 1);
				res_bytes[k] = (k < ND + 1) ? pre[k] : body[bi];
			end else begin
				bi = 2'(k);
				res_bytes[k] = (k < BODY_MAX) ? body[bi] : 8'h00;
			end
		end
	end

	assign res_cnt = squeezed ? '0
		: ((do_num ? CNT_W'(ND + 1) : '0) + CNT_W'(blen));

endmodule

@@ hdl/tvbf_emit.sv @@
// tvbf_emit: result buffer that drains one expanded byte run a byte per cycle while the output is ready
// depends on tvbf_pkg and the tvbf_out_if interface

module tvbf_emit import tvbf_pkg::*; #(
	parameter int MAX_RES = NUMBER_DIGITS_DEF + 5,
	parameter int CNT_W = $clog2(MAX_RES + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic [MAX_RES-1:0][7:0] load_bytes,
	input  logic [CNT_W-1:0]        load_cnt,
	output logic                    can_load,
	tvbf_out_if.source              out_ch
);

	logic [MAX_RES-1:0][7:0] buf_q;
	logic [CNT_W-1:0]        rem_q;
	logic                    fire;

	assign fire = out_ch.valid & out_ch.ready;

	// free now, or the last byte leaves this cycle
	assign can_load = (rem_q == '0) || ((rem_q == CNT_W'(1)) && out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= load_cnt;
		end else if (fire) begin
			rem_q <= rem_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= load_bytes;
		end else if (fire) begin
			buf_q <= {8'h00, buf_q[MAX_RES-1:1]};
		end
	end

	assign out_ch.valid    = (rem_q != '0);
	assign out_ch.out_byte = buf_q[0];
	assign out_ch.last     = (rem_q == CNT_W'(1));

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (rem_q == '0) || ((rem_q == CNT_W'(1)) && out_ch.ready))
		else $error("result buffer overwritten before drained");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !out_ch.last) |=> out_ch.valid)
		else $error("byte run ended without last");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !load) |=> (rem_q == $past(rem_q) - CNT_W'(1)))
		else $error("remaining count did not step down");

endmodule

@@ hdl/text_visible_byte_filter.sv @@
// text_visible_byte_filter: the first output byte of an accepted item appears in the cycle after accept.
// an item expanding to n bytes holds the output until its n bytes have left; the next item is taken
// as the last byte leaves, so one item per cycle when each gives one byte and the output is ready.
// rate is set by the single result buffer that drains one byte per cycle while the output is ready.
// arst_n clears config to zero, the line count and blank memory, and sets line start.

module text_visible_byte_filter import tvbf_pkg::*; #(
	parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tvbf_in_if.sink     in_ch,
	tvbf_out_if.source  out_ch,
	tvbf_cfg_if.sink    cfg_ch
);

	localparam int MAX_RES = NUMBER_DIGITS + 5;
	localparam int CNT_W   = $clog2(MAX_RES + 1);

	cfg_t                        cfg_q;
	logic                        after_nl_q;
	logic                        blank_seen_q;
	logic [4*NUMBER_DIGITS-1:0]  line_cnt_q;

	logic                        accept;
	logic                        can_load;
	logic [MAX_RES-1:0][7:0]     res_bytes;
	logic [CNT_W-1:0]            res_cnt;
	logic                        after_nl_nxt;
	logic                        blank_seen_nxt;
	logic [4*NUMBER_DIGITS-1:0]  line_cnt_nxt;

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready  = can_load;
	assign accept       = in_ch.valid & can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				CFG_SQUEEZE_BLANK:    cfg_q.squeeze_blank        <= cfg_ch.data;
				CFG_NUMBER_LINES:     cfg_q.number_lines         <= cfg_ch.data;
				CFG_NUMBER_NONBLANK:  cfg_q.number_nonblank_only <= cfg_ch.data;
				CFG_SHOW_ENDS:        cfg_q.show_ends            <= cfg_ch.data;
				CFG_SHOW_TABS:        cfg_q.show_tabs            <= cfg_ch.data;
				CFG_SHOW_NONPRINTING: cfg_q.show_nonprinting     <= cfg_ch.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_nl_q   <= 1'b1;
			blank_seen_q <= 1'b0;
			line_cnt_q   <= '0;
		end else if (accept) begin
			after_nl_q   <= after_nl_nxt;
			blank_seen_q <= blank_seen_nxt;
			line_cnt_q   <= line_cnt_nxt;
		end
	end

	tvbf_format #(
		.NUMBER_DIGITS (NUMBER_DIGITS),
		.MAX_RES       (MAX_RES),
		.CNT_W         (CNT_W)
	) u_format (
		.cfg            (cfg_q),
		.data_byte      (in_ch.data_byte),
		.file_start     (in_ch.file_start),
		.after_nl       (after_nl_q),
		.blank_seen     (blank_seen_q),
		.line_cnt       (line_cnt_q),
		.res_bytes      (res_bytes),
		.res_cnt        (res_cnt),
		.after_nl_nxt   (after_nl_nxt),
		.blank_seen_nxt (blank_seen_nxt),
		.line_cnt_nxt   (line_cnt_nxt)
	);

	tvbf_emit #(
		.MAX_RES (MAX_RES),
		.CNT_W   (CNT_W)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept),
		.load_bytes (res_bytes),
		.load_cnt   (res_cnt),
		.can_load   (can_load),
		.out_ch     (out_ch)
	);

endmodule
